[hw/rtl/cgne_pkg.sv]
// Package for the nearest-entry cell grid: entry record, function codes and
// configuration register indexes and the search status record. No dependencies.
package cgne_pkg;

  typedef struct packed {
    logic        [19:0] id;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic        [31:0] vol;
  } entry_t;

  typedef enum logic [1:0] {
    FN_CLEAR  = 2'd0,
    FN_INSERT = 2'd1,
    FN_QUERY  = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  localparam logic [2:0] CFG_ORIGIN_X    = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y    = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_Z    = 3'd2;
  localparam logic [2:0] CFG_INV_SPACING = 3'd3;
  localparam logic [2:0] CFG_CELLS_X     = 3'd4;
  localparam logic [2:0] CFG_CELLS_Y     = 3'd5;
  localparam logic [2:0] CFG_CELLS_Z     = 3'd6;

  // Search status handed from the distance pipeline to the sequencer.
  typedef struct packed {
    logic busy;
    logic found;
  } dist_stat_t;

endpackage

[hw/rtl/cgne_axis.sv]
// One axis of the cell index: difference, 32x32 product, clamp to the grid.
// Depends on nothing; three registered stages.
module cgne_axis #(
  parameter int GRID_SIDE = 16,
  localparam int AW = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1,
  localparam int NW = $clog2(GRID_SIDE + 1)
) (
  input  logic                 clk,
  input  logic signed [31:0]   pos,
  input  logic signed [31:0]   org,
  input  logic        [31:0]   inv,
  input  logic        [NW-1:0] ncell,
  output logic        [AW-1:0] idx_r,
  output logic        [AW-1:0] lo_r,
  output logic        [AW-1:0] hi_r
);

  logic signed [32:0] diff;
  logic        [31:0] mag_r;
  logic               gt_r;
  logic               gt2_r;
  logic        [63:0] prod_r;
  logic        [31:0] raw;
  logic        [31:0] nm1;
  logic        [31:0] cl;
  logic        [31:0] cl_p1;

  assign diff = {pos[31], pos} - {org[31], org};

  always_ff @(posedge clk) begin
    mag_r  <= diff[31:0];
    gt_r   <= !diff[32] && (diff != 33'sd0);
    prod_r <= {32'd0, mag_r} * {32'd0, inv};
    gt2_r  <= gt_r;
  end

  always_comb begin
    raw   = gt2_r ? prod_r[63:32] : 32'd0;
    nm1   = 32'(ncell) - 32'd1;
    cl    = (raw > nm1) ? nm1 : raw;
    cl_p1 = cl + 32'd1;
  end

  always_ff @(posedge clk) begin
    idx_r <= AW'(cl);
    lo_r  <= (cl == 32'd0) ? AW'(0) : AW'(cl - 32'd1);
    hi_r  <= (cl_p1 < 32'(ncell)) ? AW'(cl_p1) : AW'(nm1);
  end

endmodule

[hw/rtl/cgne_mem.sv]
// Cell count memory and entry memory, each one write and one registered read port.
// Depends on cgne_pkg for the entry record.
module cgne_mem
  import cgne_pkg::*;
#(
  parameter int GRID_SIDE     = 16,
  parameter int CELL_CAPACITY = 32,
  localparam int NUM_CELLS = GRID_SIDE * GRID_SIDE * GRID_SIDE,
  localparam int NUM_SLOTS = NUM_CELLS * CELL_CAPACITY,
  localparam int CAW = $clog2(NUM_CELLS),
  localparam int SAW = $clog2(NUM_SLOTS),
  localparam int CNW = $clog2(CELL_CAPACITY + 1)
) (
  input  logic           clk,
  input  logic           cnt_re,
  input  logic [CAW-1:0] cnt_raddr,
  output logic [CNW-1:0] cnt_rdata_r,
  input  logic           cnt_we,
  input  logic [CAW-1:0] cnt_waddr,
  input  logic [CNW-1:0] cnt_wdata,
  input  logic           ent_re,
  input  logic [SAW-1:0] ent_raddr,
  output entry_t         ent_rdata_r,
  input  logic           ent_we,
  input  logic [SAW-1:0] ent_waddr,
  input  entry_t         ent_wdata
);

  logic [CNW-1:0] cnt_mem [NUM_CELLS];
  entry_t         ent_mem [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rdata_r <= cnt_mem[cnt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rdata_r <= ent_mem[ent_raddr];
    end
  end

endmodule

[hw/rtl/cgne_dist.sv]
// Distance pipeline: absolute differences, squares, sum and running minimum.
// Depends on cgne_pkg; entry data arrives in the cycle after each read issue.
module cgne_dist
  import cgne_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clr,
  input  logic               issue,
  input  entry_t             rdata,
  input  logic signed [31:0] qx,
  input  logic signed [31:0] qy,
  input  logic signed [31:0] qz,
  output dist_stat_t         stat,
  output entry_t             best_r
);

  logic               v0_r, v1_r, v2_r;
  logic               found_r;
  logic        [65:0] best_d_r;
  logic signed [32:0] dx, dy, dz;
  logic        [31:0] ax_r, ay_r, az_r;
  logic        [63:0] sx_r, sy_r, sz_r;
  entry_t             e1_r, e2_r;
  logic        [65:0] sum;
  logic               upd;

  assign dx = {qx[31], qx} - {rdata.x[31], rdata.x};
  assign dy = {qy[31], qy} - {rdata.y[31], rdata.y};
  assign dz = {qz[31], qz} - {rdata.z[31], rdata.z};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= issue;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    ax_r <= dx[32] ? 32'(-dx) : dx[31:0];
    ay_r <= dy[32] ? 32'(-dy) : dy[31:0];
    az_r <= dz[32] ? 32'(-dz) : dz[31:0];
    e1_r <= rdata;
    sx_r <= {32'd0, ax_r} * {32'd0, ax_r};
    sy_r <= {32'd0, ay_r} * {32'd0, ay_r};
    sz_r <= {32'd0, az_r} * {32'd0, az_r};
    e2_r <= e1_r;
  end

  assign sum = {2'b00, sx_r} + {2'b00, sy_r} + {2'b00, sz_r};
  // Strictly smaller only, so the first entry scanned keeps a tie.
  assign upd = v2_r && (!found_r || (sum < best_d_r));

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      found_r <= 1'b0;
    end else if (upd) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      best_d_r <= sum;
      best_r   <= e2_r;
    end
  end

  assign stat.busy  = v0_r | v1_r | v2_r;
  assign stat.found = found_r;

endmodule

[hw/rtl/cell_grid_nearest_entry.sv]
// Top level of the nearest-entry cell grid: configuration, sequencer, memories.
// Depends on cgne_pkg, cgne_axis, cgne_mem and cgne_dist.
//
//   Channel   Handshake             Beat contents
//   in_*      start / busy          func, position, id, volume
//   out_*     out_strobe (1 cycle)  found, id, position, volume, status
//   cfg_*     cfg_valid / cfg_ready register index and 32-bit data
//
// A beat is taken when start is high and busy is low; busy stays high until
// the cycle after the result strobe. Insert runs the index calculation, a
// count read and the write; unused codes go straight to the result strobe.
// Clear sweeps the count memory, one cell a cycle. Query scans up to 27
// cells around the query cell; for each it reads the count, then reads the
// stored entries, at most CELL_CAPACITY, one per cycle over the single entry
// read port. After reset the same sweep clears the counts with busy high;
// configuration writes are taken throughout. The receiver cannot
// stall, so each result is shown for exactly one cycle.
module cell_grid_nearest_entry
  import cgne_pkg::*;
#(
  parameter int GRID_SIDE     = 16,
  parameter int CELL_CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic        [1:0]  in_func,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic        [19:0] in_particle_id,
  input  logic        [31:0] in_volume,
  output logic               out_strobe,
  output logic               out_found,
  output logic        [19:0] out_nearest_id,
  output logic signed [31:0] out_near_x,
  output logic signed [31:0] out_near_y,
  output logic signed [31:0] out_near_z,
  output logic        [31:0] out_near_volume,
  output logic               out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [2:0]  cfg_index,
  input  logic        [31:0] cfg_data
);

  localparam int NUM_CELLS = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int NUM_SLOTS = NUM_CELLS * CELL_CAPACITY;
  localparam int CAW = $clog2(NUM_CELLS);
  localparam int SAW = $clog2(NUM_SLOTS);
  localparam int CNW = $clog2(CELL_CAPACITY + 1);
  localparam int AW  = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int NW  = $clog2(GRID_SIDE + 1);
  localparam int PLANE = GRID_SIDE * GRID_SIDE;

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_CLR    = 13'b0000000000010,
    ST_CALC1  = 13'b0000000000100,
    ST_CALC2  = 13'b0000000001000,
    ST_CALC3  = 13'b0000000010000,
    ST_INS_RD = 13'b0000000100000,
    ST_INS_WR = 13'b0000001000000,
    ST_Q_INIT = 13'b0000010000000,
    ST_Q_CNT  = 13'b0000100000000,
    ST_Q_WAIT = 13'b0001000000000,
    ST_Q_ENT  = 13'b0010000000000,
    ST_DRAIN  = 13'b0100000000000,
    ST_EMIT   = 13'b1000000000000
  } state_t;

  // Configuration registers.
  logic signed [31:0] org_x_r, org_y_r, org_z_r;
  logic        [31:0] inv_r;
  logic        [4:0]  cells_x_r, cells_y_r, cells_z_r;
  logic [NW-1:0] nx, ny, nz;

  state_t state_r, state_nxt;

  // Latched input beat.
  func_t              func_r;
  logic signed [31:0] pos_x_r, pos_y_r, pos_z_r;
  logic        [19:0] pid_r;
  logic        [31:0] vol_r;

  logic [CAW-1:0] clr_r;
  logic           clr_emit_r;
  logic [AW-1:0]  qx_r, qy_r, qz_r;
  logic [CNW-1:0] s_r, n_r;

  logic [AW-1:0] ix, iy, iz, xlo, ylo, zlo, xhi, yhi, zhi;
  logic [CAW-1:0] cell_ins, cell_q;
  logic [SAW-1:0] slot_ins, slot_q;
  logic           last_cell;
  logic           last_slot;

  logic           cnt_re, cnt_we, ent_re, ent_we;
  logic [CAW-1:0] cnt_raddr, cnt_waddr;
  logic [CNW-1:0] cnt_rdata, cnt_wdata;
  entry_t         ent_rdata, ent_wdata, best;
  dist_stat_t     dstat;
  logic           cell_full;

  // A count register of zero acts as one cell, anything above the grid as
  // the whole grid side.
  function automatic logic [NW-1:0] eff_cells(input logic [4:0] r);
    logic [NW-1:0] v;
    if (r == 5'd0) begin
      v = NW'(1);
    end else if (32'(r) > 32'(GRID_SIDE)) begin
      v = NW'(GRID_SIDE);
    end else begin
      v = NW'(r);
    end
    return v;
  endfunction

  assign nx = eff_cells(cells_x_r);
  assign ny = eff_cells(cells_y_r);
  assign nz = eff_cells(cells_z_r);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r   <= 32'sd0;
      org_y_r   <= 32'sd0;
      org_z_r   <= 32'sd0;
      inv_r     <= 32'd65536;
      cells_x_r <= 5'd16;
      cells_y_r <= 5'd16;
      cells_z_r <= 5'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ORIGIN_X:    org_x_r   <= cfg_data;
        CFG_ORIGIN_Y:    org_y_r   <= cfg_data;
        CFG_ORIGIN_Z:    org_z_r   <= cfg_data;
        CFG_INV_SPACING: inv_r     <= cfg_data;
        CFG_CELLS_X:     cells_x_r <= cfg_data[4:0];
        CFG_CELLS_Y:     cells_y_r <= cfg_data[4:0];
        CFG_CELLS_Z:     cells_z_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Index units run every cycle off the latched position; their result passes
  // through the registered axis stages while the sequencer steps through the CALC states.
  cgne_axis #(.GRID_SIDE(GRID_SIDE)) u_ax_x (
    .clk(clk), .pos(pos_x_r), .org(org_x_r), .inv(inv_r), .ncell(nx),
    .idx_r(ix), .lo_r(xlo), .hi_r(xhi)
  );
  cgne_axis #(.GRID_SIDE(GRID_SIDE)) u_ax_y (
    .clk(clk), .pos(pos_y_r), .org(org_y_r), .inv(inv_r), .ncell(ny),
    .idx_r(iy), .lo_r(ylo), .hi_r(yhi)
  );
  cgne_axis #(.GRID_SIDE(GRID_SIDE)) u_ax_z (
    .clk(clk), .pos(pos_z_r), .org(org_z_r), .inv(inv_r), .ncell(nz),
    .idx_r(iz), .lo_r(zlo), .hi_r(zhi)
  );

  assign cell_ins = CAW'(ix) * CAW'(PLANE) + CAW'(iy) * CAW'(GRID_SIDE) + CAW'(iz);
  assign cell_q   = CAW'(qx_r) * CAW'(PLANE) + CAW'(qy_r) * CAW'(GRID_SIDE) + CAW'(qz_r);
  assign slot_ins = SAW'(cell_ins) * SAW'(CELL_CAPACITY) + SAW'(cnt_rdata);
  assign slot_q   = SAW'(cell_q) * SAW'(CELL_CAPACITY) + SAW'(s_r);

  assign last_cell = (qx_r == xhi) && (qy_r == yhi) && (qz_r == zhi);
  assign last_slot = (s_r + CNW'(1)) == n_r;
  assign cell_full = 32'(cnt_rdata) >= 32'(CELL_CAPACITY);

  // Memory port control. Accesses are strictly sequenced, so a count is
  // never read while a write to the same cell is still pending.
  always_comb begin
    cnt_re    = 1'b0;
    cnt_raddr = cell_q;
    cnt_we    = 1'b0;
    cnt_waddr = cell_ins;
    cnt_wdata = cnt_rdata + CNW'(1);
    ent_re    = 1'b0;
    ent_we    = 1'b0;
    ent_wdata = '{id: pid_r, x: pos_x_r, y: pos_y_r, z: pos_z_r, vol: vol_r};
    case (state_r)
      ST_CLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_r;
        cnt_wdata = '0;
      end
      ST_INS_RD: begin
        cnt_re    = 1'b1;
        cnt_raddr = cell_ins;
      end
      ST_INS_WR: begin
        cnt_we = !cell_full;
        ent_we = !cell_full;
      end
      ST_Q_CNT: cnt_re = 1'b1;
      ST_Q_ENT: ent_re = 1'b1;
      default: ;
    endcase
  end

  cgne_mem #(.GRID_SIDE(GRID_SIDE), .CELL_CAPACITY(CELL_CAPACITY)) u_mem (
    .clk(clk),
    .cnt_re(cnt_re), .cnt_raddr(cnt_raddr), .cnt_rdata_r(cnt_rdata),
    .cnt_we(cnt_we), .cnt_waddr(cnt_waddr), .cnt_wdata(cnt_wdata),
    .ent_re(ent_re), .ent_raddr(slot_q), .ent_rdata_r(ent_rdata),
    .ent_we(ent_we), .ent_waddr(slot_ins), .ent_wdata(ent_wdata)
  );

  cgne_dist u_dist (
    .clk(clk), .rst_n(rst_n), .clr(state_r == ST_Q_INIT), .issue(ent_re),
    .rdata(ent_rdata), .qx(pos_x_r), .qy(pos_y_r), .qz(pos_z_r),
    .stat(dstat), .best_r(best)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (func_t'(in_func))
            FN_CLEAR:  state_nxt = ST_CLR;
            FN_INSERT: state_nxt = ST_CALC1;
            FN_QUERY:  state_nxt = ST_CALC1;
            default:   state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_CLR: begin
        if (clr_r == CAW'(NUM_CELLS - 1)) begin
          state_nxt = clr_emit_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_CALC1: state_nxt = ST_CALC2;
      ST_CALC2: state_nxt = ST_CALC3;
      ST_CALC3: state_nxt = (func_r == FN_INSERT) ? ST_INS_RD : ST_Q_INIT;
      ST_INS_RD: state_nxt = ST_INS_WR;
      ST_INS_WR: state_nxt = ST_EMIT;
      ST_Q_INIT: state_nxt = ST_Q_CNT;
      ST_Q_CNT:  state_nxt = ST_Q_WAIT;
      ST_Q_WAIT: begin
        if (cnt_rdata != '0) begin
          state_nxt = ST_Q_ENT;
        end else begin
          state_nxt = last_cell ? ST_DRAIN : ST_Q_CNT;
        end
      end
      ST_Q_ENT: begin
        if (last_slot) begin
          state_nxt = last_cell ? ST_DRAIN : ST_Q_CNT;
        end
      end
      ST_DRAIN: state_nxt = dstat.busy ? ST_DRAIN : ST_EMIT;
      ST_EMIT:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      clr_r      <= '0;
      clr_emit_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE && start) begin
        clr_r      <= '0;
        clr_emit_r <= 1'b1;
      end else if (state_r == ST_CLR) begin
        clr_r <= clr_r + CAW'(1);
      end
    end
  end

  // Input beat capture, scan position and result registers.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      func_r  <= func_t'(in_func);
      pos_x_r <= in_pos_x;
      pos_y_r <= in_pos_y;
      pos_z_r <= in_pos_z;
      pid_r   <= in_particle_id;
      vol_r   <= in_volume;
      out_found       <= 1'b0;
      out_nearest_id  <= '0;
      out_near_x      <= '0;
      out_near_y      <= '0;
      out_near_z      <= '0;
      out_near_volume <= '0;
      out_status      <= 1'b0;
    end
    if (state_r == ST_INS_WR) begin
      out_status <= cell_full;
    end
    if (state_r == ST_Q_INIT) begin
      qx_r <= xlo;
      qy_r <= ylo;
      qz_r <= zlo;
    end
    if (state_r == ST_Q_WAIT) begin
      n_r <= cnt_rdata;
      s_r <= '0;
    end
    if (state_r == ST_Q_ENT) begin
      s_r <= s_r + CNW'(1);
    end
    // Step to the next cell, z innermost, then y, then x.
    if ((state_r == ST_Q_WAIT && cnt_rdata == '0) || (state_r == ST_Q_ENT && last_slot)) begin
      if (qz_r != zhi) begin
        qz_r <= qz_r + AW'(1);
      end else begin
        qz_r <= zlo;
        if (qy_r != yhi) begin
          qy_r <= qy_r + AW'(1);
        end else begin
          qy_r <= ylo;
          qx_r <= qx_r + AW'(1);
        end
      end
    end
    if (state_r == ST_DRAIN && !dstat.busy && dstat.found) begin
      out_found       <= 1'b1;
      out_nearest_id  <= best.id;
      out_near_x      <= best.x;
      out_near_y      <= best.y;
      out_near_z      <= best.z;
      out_near_volume <= best.vol;
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = (state_r == ST_EMIT);

endmodule

[hw/rtl/cgne_checker.sv]
// Port-level checks of the nearest-entry cell grid, bound to the top level.
// Depends on the top level's ports only.
module cgne_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input logic        out_found,
  input logic [19:0] out_nearest_id,
  input logic [31:0] out_near_volume,
  input logic        out_status
);

  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_strobe_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy ##1 !busy)
    else $error("result strobe not in the last busy cycle");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_found |-> out_nearest_id == 20'd0 && out_near_volume == 32'd0)
    else $error("result without a match carries data");

  a_drop_nofind: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status |-> !out_found)
    else $error("dropped insert reports a match");

endmodule

bind cell_grid_nearest_entry cgne_checker u_cgne_checker (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .out_strobe(out_strobe),
  .out_found(out_found),
  .out_nearest_id(out_nearest_id),
  .out_near_volume(out_near_volume),
  .out_status(out_status)
);
